@@ src/sbks_pkg.sv @@
// Shared types and constants for the stable binary key sort block.
// No dependencies; every other file in src except sbks_ram refers to this package by scoped name.
package sbks_pkg;

	// Default and largest supported store depth (records per batch)
	localparam int unsigned DEPTH_DEF  = 64;
	localparam int unsigned DEPTH_MAX  = 64;
	// Count field wide enough to hold DEPTH_MAX itself
	localparam int unsigned CNT_W      = $clog2(DEPTH_MAX + 1);
	// Two store banks: one fills while the other drains
	localparam int unsigned NBANK      = 2;
	// Result queue depth in the back end
	localparam int unsigned OUTQ_DEPTH = 4;
	// Stored record: {key, payload}
	localparam int unsigned REC_W      = 9;

	typedef struct packed {
		logic       key;
		logic [7:0] payload;
		logic       batch_end;
	} rec_t;

	typedef struct packed {
		logic       out_key;
		logic [7:0] out_payload;
		logic       out_last;
		logic       overflow;
	} res_t;

	// One finished batch handed from front to back
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             dropped;
	} desc_t;

endpackage

@@ src/stable_binary_key_sort.sv @@
// Stable binary key sort, top level; uses sbks_pkg, sbks_front, sbks_descq, sbks_ram, sbks_back.
// Throughput: one record request per cycle while loading and full is low; a batch of N stored records
// drains in two read passes, set by the single read port walking the bank once per key.
// The first result of a batch passes through the descriptor queue, the registered store read and the
// result queue before it is visible; loading stalls while both banks wait.
// Reset (arst_n low) clears all control state at once; the store itself is not cleared.
module stable_binary_key_sort #(
	parameter int unsigned DEPTH = sbks_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbks_pkg::rec_t rec,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output sbks_pkg::res_t result
);

	localparam int unsigned IW    = $clog2(DEPTH);
	localparam int unsigned AW    = IW + 1;
	localparam int unsigned RAM_D = 2 * (1 << IW);

	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [sbks_pkg::REC_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [AW-1:0]              mem_raddr;
	logic [sbks_pkg::REC_W-1:0] mem_rdata;

	logic            dq_push;
	logic            dq_full;
	logic            dq_pop;
	logic            dq_valid;
	sbks_pkg::desc_t dq_din;
	sbks_pkg::desc_t dq_dout;

	// Accept and store records
	sbks_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rec       (rec),
		.full      (full),
		.desc_full (dq_full),
		.desc_push (dq_push),
		.desc      (dq_din),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	// Hand finished batches to the back end
	sbks_descq u_descq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (dq_push),
		.din    (dq_din),
		.full   (dq_full),
		.pop    (dq_pop),
		.valid  (dq_valid),
		.dout   (dq_dout)
	);

	// Two-bank record store
	sbks_ram #(.WIDTH(sbks_pkg::REC_W), .DEPTH(RAM_D)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Drain batches in key order
	sbks_back #(.DEPTH(DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (dq_valid),
		.desc       (dq_dout),
		.desc_pop   (dq_pop),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

@@ src/sbks_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbks_ram #(
	parameter int unsigned WIDTH = 9,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/sbks_front.sv @@
// Front end: accepts records, writes them into the current store bank and
// closes a batch into a descriptor. Depends on sbks_pkg.
module sbks_front #(
	parameter int unsigned DEPTH = sbks_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  sbks_pkg::rec_t                   rec,
	output logic                             full,
	input  logic                             desc_full,
	output logic                             desc_push,
	output sbks_pkg::desc_t                  desc,
	output logic                             mem_we,
	output logic [$clog2(DEPTH):0]           mem_waddr,
	output logic [sbks_pkg::REC_W-1:0]       mem_wdata
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);

	logic          bank_q;
	logic [CW-1:0] fill_q;
	logic          drop_q;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] fill_nxt;
	logic          drop_nxt;

	// Stall the producer while both banks are owned by pending batches
	assign full   = desc_full;
	assign accept = push & ~desc_full;

	// Store while there is room, otherwise drop and flag
	assign has_room = (fill_q != CW'(DEPTH));
	assign fill_nxt = has_room ? (fill_q + CW'(1)) : fill_q;
	assign drop_nxt = drop_q | ~has_room;

	assign mem_we    = accept & has_room;
	assign mem_waddr = {bank_q, fill_q[IW-1:0]};
	assign mem_wdata = {rec.key, rec.payload};

	// Close the batch on its final record
	assign desc_push    = accept & rec.batch_end;
	assign desc.bank    = bank_q;
	assign desc.count   = sbks_pkg::CNT_W'(fill_nxt);
	assign desc.dropped = drop_nxt;

	// Advance fill state; restart and swap banks at batch end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			fill_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (rec.batch_end) begin
				bank_q <= ~bank_q;
				fill_q <= '0;
				drop_q <= 1'b0;
			end else begin
				fill_q <= fill_nxt;
				drop_q <= drop_nxt;
			end
		end
	end

endmodule

@@ src/sbks_descq.sv @@
// Short queue of finished-batch descriptors between front and back end.
// Depends on sbks_pkg.
module sbks_descq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sbks_pkg::desc_t din,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output sbks_pkg::desc_t dout
);

	localparam int unsigned PW = $clog2(sbks_pkg::NBANK);
	localparam int unsigned QW = $clog2(sbks_pkg::NBANK + 1);

	sbks_pkg::desc_t ent_q [sbks_pkg::NBANK];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [QW-1:0]   cnt_q;

	logic do_push;
	logic do_pop;

	assign full    = (cnt_q == QW'(sbks_pkg::NBANK));
	assign valid   = (cnt_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign dout    = ent_q[rp_q];

	// Hold descriptor contents
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QW'(1);
				2'b01:   cnt_q <= cnt_q - QW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ src/sbks_back.sv @@
// Back end: drains one batch per descriptor in two read passes (key 0, then
// key 1) and queues the results. Depends on sbks_pkg.
module sbks_back #(
	parameter int unsigned DEPTH = sbks_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       desc_valid,
	input  sbks_pkg::desc_t            desc,
	output logic                       desc_pop,
	output logic                       mem_re,
	output logic [$clog2(DEPTH):0]     mem_raddr,
	input  logic [sbks_pkg::REC_W-1:0] mem_rdata,
	output logic                       empty,
	input  logic                       pop,
	output sbks_pkg::res_t             result
);

	localparam int unsigned CW    = $clog2(DEPTH + 1);
	localparam int unsigned IW    = $clog2(DEPTH);
	localparam int unsigned OQ_PW = $clog2(sbks_pkg::OUTQ_DEPTH);
	localparam int unsigned OQ_CW = $clog2(sbks_pkg::OUTQ_DEPTH + 1);

	// Read sequencer
	logic          pass_q;
	logic          issued_q;
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] emit_q;
	// Read in flight
	logic          valid_s1;
	logic          pass_s1;
	logic          final_s1;
	// Result queue
	sbks_pkg::res_t oq_q [sbks_pkg::OUTQ_DEPTH];
	logic [OQ_PW-1:0] oq_wp_q;
	logic [OQ_PW-1:0] oq_rp_q;
	logic [OQ_CW-1:0] oq_cnt_q;

	logic [CW-1:0]    cnt;
	logic [CW-1:0]    rd_nxt;
	logic             rd_wrap;
	logic [OQ_CW-1:0] oq_load;
	logic             room;
	logic             issue;
	logic             hit;
	logic             oq_pop;
	sbks_pkg::res_t   res_in;

	assign cnt     = desc.count[CW-1:0];
	assign rd_nxt  = rd_idx_q + CW'(1);
	assign rd_wrap = (rd_nxt == cnt);

	// Issue a read only when the result queue can absorb it and the one in flight
	assign oq_load = oq_cnt_q + OQ_CW'(valid_s1);
	assign room    = (oq_load < OQ_CW'(sbks_pkg::OUTQ_DEPTH));
	assign issue   = desc_valid & ~issued_q & room;

	assign mem_re    = issue;
	assign mem_raddr = {desc.bank, rd_idx_q[IW-1:0]};

	// Filter returned record by the key of the current pass
	assign hit                = valid_s1 & (mem_rdata[8] == pass_s1);
	assign res_in.out_key     = mem_rdata[8];
	assign res_in.out_payload = mem_rdata[7:0];
	assign res_in.out_last    = ((emit_q + CW'(1)) == cnt);
	assign res_in.overflow    = desc.dropped;

	// Release the bank once the final read has returned
	assign desc_pop = valid_s1 & final_s1;

	// Step through the store twice per batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q   <= 1'b0;
			issued_q <= 1'b0;
			rd_idx_q <= '0;
			emit_q   <= '0;
			valid_s1 <= 1'b0;
			pass_s1  <= 1'b0;
			final_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			pass_s1  <= pass_q;
			final_s1 <= pass_q & rd_wrap;
			if (desc_pop) begin
				pass_q   <= 1'b0;
				issued_q <= 1'b0;
				rd_idx_q <= '0;
				emit_q   <= '0;
			end else begin
				if (issue) begin
					if (rd_wrap) begin
						rd_idx_q <= '0;
						if (pass_q) begin
							issued_q <= 1'b1;
						end else begin
							pass_q <= 1'b1;
						end
					end else begin
						rd_idx_q <= rd_nxt;
					end
				end
				if (hit) begin
					emit_q <= emit_q + CW'(1);
				end
			end
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (hit) begin
			oq_q[oq_wp_q] <= res_in;
		end
	end

	assign empty  = (oq_cnt_q == '0);
	assign oq_pop = pop & ~empty;
	assign result = oq_q[oq_rp_q];

	// Result queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (hit) begin
				oq_wp_q <= oq_wp_q + OQ_PW'(1);
			end
			if (oq_pop) begin
				oq_rp_q <= oq_rp_q + OQ_PW'(1);
			end
			case ({hit, oq_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

endmodule

@@ test/tb.sv @@
// Testbench for stable_binary_key_sort: random batches of keyed records against a local sorter.
// Depends on sbks_pkg and the block's RTL; checks every result record field by field.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH     = sbks_pkg::DEPTH_DEF;
	localparam int          HOLD_AT   = 160;
	localparam int          HOLD_LEN  = 500;
	localparam int          ITEMS     = 330;

	typedef struct {
		sbks_pkg::rec_t r;
		int             gap;
	} req_slot_t;

	logic           clk    = 1'b0;
	logic           arst_n = 1'b0;
	logic           push   = 1'b0;
	sbks_pkg::rec_t rec    = '0;
	logic           pop    = 1'b0;
	logic           full;
	logic           empty;
	sbks_pkg::res_t result;

	// requests still to offer, results the sorter predicts
	req_slot_t      req_queue[$];
	sbks_pkg::res_t sorted_due[$];

	// local sorter state
	sbks_pkg::rec_t batch_store[DEPTH];
	int             batch_fill    = 0;
	bit             batch_dropped = 1'b0;

	int records_taken = 0;
	int n_records     = 0;
	int errors        = 0;
	int cycles        = 0;
	int hold_left     = 0;
	bit hold_done     = 1'b0;

	int        idle_left = 0;
	int        cur_gap   = 0;
	int        pop_wait  = 0;
	req_slot_t next_req;

	stable_binary_key_sort #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.rec    (rec),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #5 clk = ~clk;

	// Store one record; on batch end emit key-0 records then key-1 records in arrival order
	function automatic void absorb_record(sbks_pkg::rec_t r);
		sbks_pkg::res_t o;
		int             n;
		if (batch_fill < DEPTH) begin
			batch_store[batch_fill] = r;
			batch_fill++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (!r.batch_end)
			return;
		n = 0;
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < batch_fill; i++) begin
				if (batch_store[i].key == k[0]) begin
					n++;
					o.out_key     = batch_store[i].key;
					o.out_payload = batch_store[i].payload;
					o.out_last    = (n == batch_fill);
					o.overflow    = batch_dropped;
					sorted_due    = {sorted_due, o};
				end
			end
		end
		batch_fill    = 0;
		batch_dropped = 1'b0;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void add_record(bit k, bit [7:0] p, bit e, int gap);
		req_slot_t s;
		s.r.key       = k;
		s.r.payload   = p;
		s.r.batch_end = e;
		s.gap         = gap;
		req_queue     = {req_queue, s};
		n_records++;
	endfunction

	function automatic void add_batch(int size, bit burst);
		for (int i = 0; i < size; i++)
			add_record(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), i == size - 1,
				burst ? 0 : pick_gap());
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// Driver: predict on each accepted request, hold while full, then idle or load the next
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				absorb_record(rec);
				records_taken <= records_taken + 1;
				idle_left = cur_gap;
			end
			if (push && full) begin
				// hold the offered request
			end else if (idle_left > 0) begin
				push <= 1'b0;
				idle_left--;
			end else if (req_queue.size() > 0) begin
				next_req = req_queue.pop_front();
				rec     <= next_req.r;
				cur_gap  = next_req.gap;
				push    <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Count cycles and run one long receiver hold-off once the sender is well under way
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!hold_done && records_taken >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: compare each accepted result with the oldest predicted one, then pace pop
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected result, got %0h", $time, result);
					errors++;
				end else begin
					check_field("out_key", sorted_due[0].out_key, result.out_key);
					check_field("out_payload", sorted_due[0].out_payload, result.out_payload);
					check_field("out_last", sorted_due[0].out_last, result.out_last);
					check_field("overflow", sorted_due[0].overflow, result.overflow);
					void'(sorted_due.pop_front());
				end
				// every third stretch of the cycle counter pops without idling
				pop_wait = ((cycles / 400) % 3 == 0) ? 0 : pick_gap();
			end else if (pop_wait > 0) begin
				pop_wait--;
			end
			pop <= (pop_wait == 0) && (hold_left == 0);
		end
	end

	// Stimulus, reset and end of run
	initial begin
		int r;
		// single records of either key at the payload extremes
		add_record(1'b0, 8'h00, 1'b1, pick_gap());
		add_record(1'b1, 8'hFF, 1'b1, pick_gap());
		// mixed keys: order inside each key must hold
		add_record(1'b1, 8'h01, 1'b0, pick_gap());
		add_record(1'b0, 8'h80, 1'b0, pick_gap());
		add_record(1'b1, 8'h7F, 1'b0, pick_gap());
		add_record(1'b0, 8'hFE, 1'b0, pick_gap());
		add_record(1'b0, 8'h55, 1'b0, pick_gap());
		add_record(1'b1, 8'hAA, 1'b1, pick_gap());
		// all key 1, then all key 0
		add_record(1'b1, 8'h10, 1'b0, pick_gap());
		add_record(1'b1, 8'h20, 1'b0, pick_gap());
		add_record(1'b1, 8'h30, 1'b1, pick_gap());
		add_record(1'b0, 8'h11, 1'b0, pick_gap());
		add_record(1'b0, 8'h22, 1'b0, pick_gap());
		add_record(1'b0, 8'h33, 1'b1, pick_gap());
		// two-record batches in both key orders
		add_record(1'b0, 8'hC3, 1'b0, pick_gap());
		add_record(1'b1, 8'h3C, 1'b1, pick_gap());
		add_record(1'b1, 8'h0F, 1'b0, pick_gap());
		add_record(1'b0, 8'hF0, 1'b1, pick_gap());

		// store overflow with a dropped batch end, then an exactly full store
		add_batch(DEPTH + 3, 1'b0);
		add_batch(DEPTH, 1'b1);
		while (n_records < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				add_batch($urandom_range(1, 8), $urandom_range(0, 4) == 0);
			else if (r < 95)
				add_batch($urandom_range(9, 40), $urandom_range(0, 4) == 0);
			else
				add_batch(DEPTH + 1, 1'b0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (records_taken != n_records)
			@(posedge clk);
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Timeout
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
